// ----- rtl/sobel_edge_threshold_defines.svh -----
// Assertion helpers shared by the block's modules.
`ifndef SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SEDGE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SEDGE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sedge_pkg.sv -----
package sedge_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned FifoDepth    = 4;

  localparam int unsigned PixW    = 8;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GradW   = 12;
  localparam int unsigned SqW     = 21;
  localparam int unsigned MagW    = 22;

  localparam logic [CfgIdxW-1:0] RegFrameWidth    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEdgeThreshold = 2'd2;

  localparam int unsigned WidthRst     = 512;
  localparam int unsigned HeightRst    = 512;
  localparam int unsigned ThresholdRst = 38;

  localparam logic [PixW-1:0] PixEdge = 8'd0;
  localparam logic [PixW-1:0] PixFlat = 8'd255;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            draining;
    logic            col_valid;
    logic            top_from_mid;
    logic            emit;
    logic            l_edge;
    logic            r_edge;
    logic            last;
  } cmd_t;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < 1) r = 1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- rtl/sobel_edge_threshold.sv -----
// Sobel 3x3 edge detector with magnitude threshold.
// Input stream (s_axis): one grey pixel per request in raster order, tdata = pixel
// value, tuser = flush. After the last pixel of a frame send frame_width + 1 flush
// requests to drain the results still pending; a flush before frame end is dropped.
// Output stream (m_axis): tdata = 0 for an edge, 255 otherwise; tlast marks the last
// result of a frame. Results trail the input by one row plus one pixel.
// Configuration channel: frame width at index 0, frame height at index 1, edge threshold at index 2.
// Writing width or height restarts the frame at row 0, column 0. Write only while idle.
// Throughput: one request per clock while s_axis_tready is high. An accepted request
// passes the request queue with the registered line store read, then the window, the
// gradient adders, the square stage and the compare before it drives m_axis_tvalid.
// The line stores hold no reset state and need no clearing pass; border replication
// hides stale rows. Reset restores width 512, height 512, threshold 38.
// When the sink stalls, the back pipeline holds; the front keeps accepting until the
// four-entry request queue fills, then deasserts s_axis_tready.
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = sedge_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = sedge_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sedge_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sedge_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel_value
  input  logic                          s_axis_tuser,   // [0] flush
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] edge_pixel
  output logic                          m_axis_tlast
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned FDW = $bits(sedge_pkg::cmd_t) + AW;

  sedge_pkg::cmd_t            f_cmd, q_cmd;
  logic [AW-1:0]              f_addr, q_addr;
  logic                       push, pop, full, empty;
  logic [sedge_pkg::MagW-1:0] thr_sq;
  logic [FDW-1:0]             q_rdata;

  sedge_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .pixel_value_i(s_axis_tdata),
    .flush_i      (s_axis_tuser),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (f_cmd),
    .addr_o       (f_addr),
    .thr_sq_o     (thr_sq)
  );

  sedge_fifo #(
    .DW(FDW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({f_addr, f_cmd}),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (full),
    .empty_o(empty)
  );

  assign q_cmd  = q_rdata[$bits(sedge_pkg::cmd_t)-1:0];
  assign q_addr = q_rdata[FDW-1:$bits(sedge_pkg::cmd_t)];

  sedge_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .addr_i      (q_addr),
    .empty_i     (empty),
    .pop_o       (pop),
    .thr_sq_i    (thr_sq),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .edge_pixel_o(m_axis_tdata),
    .frame_end_o (m_axis_tlast)
  );

endmodule

// ----- rtl/sedge_front.sv -----
`include "sobel_edge_threshold_defines.svh"

module sedge_front #(
  parameter int unsigned MAX_WIDTH  = sedge_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = sedge_pkg::MaxHeightDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sedge_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sedge_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [sedge_pkg::PixW-1:0]          pixel_value_i,
  input  logic                                flush_i,
  input  logic                                full_i,
  output logic                                push_o,
  output sedge_pkg::cmd_t                     cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr_o,
  output logic [sedge_pkg::MagW-1:0]          thr_sq_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam logic [CW-1:0] WRst =
    CW'(sedge_pkg::clamp_dim(sedge_pkg::WidthRst, MAX_WIDTH));
  localparam logic [HW-1:0] HRst =
    HW'(sedge_pkg::clamp_dim(sedge_pkg::HeightRst, MAX_HEIGHT));
  localparam logic [sedge_pkg::MagW-1:0] ThrSqRst =
    sedge_pkg::MagW'(sedge_pkg::ThresholdRst * sedge_pkg::ThresholdRst);

  logic [CW-1:0]              w_q, w_d;
  logic [HW-1:0]              h_q, h_d;
  logic [sedge_pkg::MagW-1:0] thr_sq_q, thr_sq_d, thr_ext;
  logic [CW-1:0]              ic_q, ic_d;
  logic [HW-1:0]              ir_q, ir_d;
  logic                       draining, ic_zero, col_valid, drop, accept, ic_wrap, cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign s_tready_o  = !full_i;

  always_comb begin
    draining  = ir_q >= h_q;
    ic_zero   = ic_q == '0;
    col_valid = ic_q < w_q;
    drop      = !draining && flush_i;
    accept    = s_tvalid_i && !full_i;
    push_o    = accept && !drop;
    ic_wrap   = draining ? (ic_q == w_q) : (ic_q == w_q - CW'(1));

    cmd_o.pix          = pixel_value_i;
    cmd_o.draining     = draining;
    cmd_o.col_valid    = col_valid;
    cmd_o.top_from_mid = ir_q == HW'(1);
    cmd_o.emit         = ic_zero ? (ir_q >= HW'(2)) : (ir_q >= HW'(1));
    cmd_o.l_edge       = ic_zero ? (w_q < CW'(2)) : (ic_q < CW'(2));
    cmd_o.r_edge       = ic_zero ? 1'b1 : !col_valid;
    cmd_o.last         = draining && (ic_q == w_q);
    addr_o             = ic_q[AW-1:0];
  end

  always_comb begin
    w_d      = w_q;
    h_d      = h_q;
    thr_sq_d = thr_sq_q;
    ic_d     = ic_q;
    ir_d     = ir_q;
    thr_ext  = sedge_pkg::MagW'(cfg_data_i);
    if (cfg_wr) begin
      unique case (cfg_index_i)
        sedge_pkg::RegFrameWidth: begin
          w_d  = CW'(sedge_pkg::clamp_dim(int'(cfg_data_i), MAX_WIDTH));
          ic_d = '0;
          ir_d = '0;
        end
        sedge_pkg::RegFrameHeight: begin
          h_d  = HW'(sedge_pkg::clamp_dim(int'(cfg_data_i), MAX_HEIGHT));
          ic_d = '0;
          ir_d = '0;
        end
        sedge_pkg::RegEdgeThreshold: begin
          thr_sq_d = thr_ext * thr_ext;
        end
        default: begin
        end
      endcase
    end else if (push_o) begin
      if (ic_wrap) begin
        ic_d = '0;
        ir_d = draining ? '0 : ir_q + HW'(1);
      end else begin
        ic_d = ic_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WRst;
      h_q      <= HRst;
      thr_sq_q <= ThrSqRst;
      ic_q     <= '0;
      ir_q     <= '0;
    end else begin
      w_q      <= w_d;
      h_q      <= h_d;
      thr_sq_q <= thr_sq_d;
      ic_q     <= ic_d;
      ir_q     <= ir_d;
    end
  end

  assign thr_sq_o = thr_sq_q;

  `SEDGE_ASSERT_IMP(a_col_in_range, 1'b1, ic_q <= w_q, "input column beyond frame width")
  `SEDGE_ASSERT_IMP(a_row_in_range, 1'b1, ir_q <= h_q, "input row beyond frame height")

endmodule

// ----- rtl/sedge_fifo.sv -----
`include "sobel_edge_threshold_defines.svh"

module sedge_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PW   = $clog2(sedge_pkg::FifoDepth);
  localparam int unsigned CNTW = $clog2(sedge_pkg::FifoDepth + 1);
  localparam logic [PW-1:0]   PtrLast = PW'(sedge_pkg::FifoDepth - 1);
  localparam logic [CNTW-1:0] CntFull = CNTW'(sedge_pkg::FifoDepth);

  logic [DW-1:0]   mem_q [sedge_pkg::FifoDepth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o  = cnt_q == CntFull;
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  `SEDGE_ASSERT_IMP(a_no_overflow, push_i, !full_o, "request pushed into full queue")
  `SEDGE_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "request popped from empty queue")

endmodule

// ----- rtl/sedge_back.sv -----
`include "sobel_edge_threshold_defines.svh"

module sedge_back #(
  parameter int unsigned MAX_WIDTH = sedge_pkg::MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sedge_pkg::cmd_t              cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  logic [sedge_pkg::MagW-1:0]   thr_sq_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [sedge_pkg::PixW-1:0]   edge_pixel_o,
  output logic                         frame_end_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = sedge_pkg::PixW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned GW = sedge_pkg::GradW;

  logic [PW-1:0] up_mem  [MAX_WIDTH];
  logic [PW-1:0] mid_mem [MAX_WIDTH];

  logic adv, a_v, a_rd, a_wr, b_wr, conflict;

  logic            b_v_q, byp_q;
  sedge_pkg::cmd_t b_cmd_q;
  logic [AW-1:0]   b_addr_q;
  logic [PW-1:0]   rd_up_q, rd_mid_q, byp_pix_q;
  logic [PW-1:0]   up_val, new_top, new_bot;
  logic [PW-1:0]   win_q [3][3];

  logic            c_v_q;
  sedge_pkg::cmd_t c_cmd_q;
  logic [PW-1:0]   col_l [3];
  logic [PW-1:0]   col_r [3];
  logic [SW-1:0]   top_sum, bot_sum, left_sum, right_sum;
  logic signed [GW-1:0] gx, gy;

  logic                 d_v_q, d_emit_q, d_last_q;
  logic signed [GW-1:0] gx_q, gy_q;
  logic signed [2*GW-1:0] sqx_full, sqy_full;

  logic                         e_v_q, e_emit_q, e_last_q;
  logic [sedge_pkg::SqW-1:0]    sqx_q, sqy_q;
  logic [sedge_pkg::MagW-1:0]   mag;

  logic          out_v_q, out_last_q;
  logic [PW-1:0] out_pix_q;

  assign adv      = !out_v_q || m_tready_i;
  assign a_v      = !empty_i;
  assign pop_o    = adv && a_v;
  assign a_rd     = a_v && cmd_i.col_valid;
  assign a_wr     = a_rd && !cmd_i.draining;
  assign b_wr     = b_v_q && b_cmd_q.col_valid && !b_cmd_q.draining;
  assign conflict = b_wr && a_rd && (addr_i == b_addr_q);

  always_ff @(posedge clk_i) begin
    if (adv && a_rd) begin
      rd_mid_q <= mid_mem[addr_i];
    end
    if (adv && a_wr) begin
      mid_mem[addr_i] <= cmd_i.pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_rd) begin
      rd_up_q <= up_mem[addr_i];
    end
    if (adv && b_wr) begin
      up_mem[b_addr_q] <= rd_mid_q;
    end
  end

  always_comb begin
    up_val  = byp_q ? byp_pix_q : rd_up_q;
    new_top = b_cmd_q.top_from_mid ? rd_mid_q : up_val;
    new_bot = b_cmd_q.draining ? rd_mid_q : b_cmd_q.pix;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      col_l[r] = c_cmd_q.l_edge ? win_q[r][1] : win_q[r][0];
      col_r[r] = c_cmd_q.r_edge ? win_q[r][1] : win_q[r][2];
    end
    top_sum   = SW'(col_l[0]) + {1'b0, win_q[0][1], 1'b0} + SW'(col_r[0]);
    bot_sum   = SW'(col_l[2]) + {1'b0, win_q[2][1], 1'b0} + SW'(col_r[2]);
    left_sum  = SW'(col_l[0]) + {1'b0, col_l[1], 1'b0} + SW'(col_l[2]);
    right_sum = SW'(col_r[0]) + {1'b0, col_r[1], 1'b0} + SW'(col_r[2]);
    gx        = $signed({2'b00, bot_sum}) - $signed({2'b00, top_sum});
    gy        = $signed({2'b00, right_sum}) - $signed({2'b00, left_sum});
  end

  assign sqx_full = gx_q * gx_q;
  assign sqy_full = gy_q * gy_q;
  assign mag      = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_cmd_q   <= cmd_i;
      b_addr_q  <= addr_i;
      byp_pix_q <= rd_mid_q;
      c_cmd_q   <= b_cmd_q;
      d_emit_q  <= c_cmd_q.emit;
      d_last_q  <= c_cmd_q.last;
      gx_q      <= gx;
      gy_q      <= gy;
      e_emit_q  <= d_emit_q;
      e_last_q  <= d_last_q;
      sqx_q     <= sqx_full[sedge_pkg::SqW-1:0];
      sqy_q     <= sqy_full[sedge_pkg::SqW-1:0];
      out_pix_q <= (mag >= thr_sq_i) ? sedge_pkg::PixEdge : sedge_pkg::PixFlat;
      out_last_q <= e_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      byp_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (adv) begin
      b_v_q   <= a_v;
      byp_q   <= conflict;
      c_v_q   <= b_v_q;
      d_v_q   <= c_v_q;
      e_v_q   <= d_v_q;
      out_v_q <= e_v_q && e_emit_q;
      if (b_v_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        if (b_cmd_q.col_valid) begin
          win_q[0][2] <= new_top;
          win_q[1][2] <= rd_mid_q;
          win_q[2][2] <= new_bot;
        end
      end
    end
  end

  assign m_tvalid_o   = out_v_q;
  assign edge_pixel_o = out_pix_q;
  assign frame_end_o  = out_last_q;

  `SEDGE_ASSERT_IMP(a_byp_has_owner, byp_q, b_v_q, "row bypass without a request in stage b")
  `SEDGE_ASSERT_NXT(a_stall_holds_tail, !adv && e_v_q, e_v_q && $stable(sqx_q), "stalled tail moved")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned ItemTarget   = 750;
  localparam int unsigned SettleCycles = 12;

  typedef enum int unsigned {TexNoise, TexBinary, TexRamp} texture_e;

  typedef struct {
    bit [sedge_pkg::PixW-1:0] edge_pixel;
    bit                       frame_end;
  } edge_result_t;

  class edge_scoreboard;
    bit [sedge_pkg::CfgW-1:0] width_reg;
    bit [sedge_pkg::CfgW-1:0] height_reg;
    bit [sedge_pkg::CfgW-1:0] threshold_reg;
    bit [sedge_pkg::PixW-1:0] upper_row[sedge_pkg::MaxWidthDef];
    bit [sedge_pkg::PixW-1:0] middle_row[sedge_pkg::MaxWidthDef];
    bit [sedge_pkg::PixW-1:0] win[9];
    int unsigned   in_col;
    int unsigned   in_row;
    edge_result_t  expected_edges[$];
    int unsigned   mismatch_count;
    int unsigned   checked_count;
    int unsigned   frames_closed;

    function new();
      width_reg     = sedge_pkg::CfgW'(sedge_pkg::WidthRst);
      height_reg    = sedge_pkg::CfgW'(sedge_pkg::HeightRst);
      threshold_reg = sedge_pkg::CfgW'(sedge_pkg::ThresholdRst);
    endfunction

    function int unsigned dim_of(bit [sedge_pkg::CfgW-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int tap(int rr, int cc);
      return int'(win[rr * 3 + cc]);
    endfunction

    function void write_reg(bit [sedge_pkg::CfgIdxW-1:0] idx, bit [sedge_pkg::CfgW-1:0] val);
      case (idx)
        sedge_pkg::RegFrameWidth: begin
          width_reg = val;
          in_col    = 0;
          in_row    = 0;
        end
        sedge_pkg::RegFrameHeight: begin
          height_reg = val;
          in_col     = 0;
          in_row     = 0;
        end
        sedge_pkg::RegEdgeThreshold: threshold_reg = val;
        default: ;
      endcase
    endfunction

    function void note_request(bit [sedge_pkg::PixW-1:0] pix, bit flush);
      int unsigned  w, h, c, r;
      int           lft, rgt, gx, gy, mag2, thr;
      bit           drain, emit, last;
      bit [sedge_pkg::PixW-1:0] top, mid;
      edge_result_t res;
      w = dim_of(width_reg, sedge_pkg::MaxWidthDef);
      h = dim_of(height_reg, sedge_pkg::MaxHeightDef);
      c = in_col;
      r = in_row;
      drain = (r >= h);
      if (!drain && flush) return;
      if (c > w) c = w;
      for (int k = 0; k < 3; k++) begin
        win[k * 3]     = win[k * 3 + 1];
        win[k * 3 + 1] = win[k * 3 + 2];
      end
      if (c < w) begin
        top = upper_row[c];
        mid = middle_row[c];
        if (r == 1) top = mid;
        win[2] = top;
        win[5] = mid;
        win[8] = drain ? mid : pix;
        if (!drain) begin
          upper_row[c]  = mid;
          middle_row[c] = pix;
        end
      end else begin
        for (int k = 0; k < 3; k++) win[k * 3 + 2] = win[k * 3 + 1];
      end
      if (c == 0) begin
        emit = (r >= 2);
        lft  = (w >= 2) ? 0 : 1;
        rgt  = 1;
      end else begin
        emit = (r >= 1);
        lft  = (c >= 2) ? 0 : 1;
        rgt  = (c < w) ? 2 : 1;
      end
      last = drain && (c == w);
      c++;
      if (!drain) begin
        if (c >= w) begin
          c = 0;
          r++;
        end
      end else if (c > w) begin
        c = 0;
        r = 0;
      end
      in_col = c;
      in_row = r;
      if (emit) begin
        gx = (tap(2, lft) + 2 * tap(2, 1) + tap(2, rgt))
           - (tap(0, lft) + 2 * tap(0, 1) + tap(0, rgt));
        gy = (tap(0, rgt) + 2 * tap(1, rgt) + tap(2, rgt))
           - (tap(0, lft) + 2 * tap(1, lft) + tap(2, lft));
        mag2 = gx * gx + gy * gy;
        thr  = int'(threshold_reg);
        res.edge_pixel = (mag2 >= thr * thr) ? sedge_pkg::PixEdge : sedge_pkg::PixFlat;
        res.frame_end  = last;
        expected_edges.push_back(res);
        if (last) frames_closed++;
      end
    endfunction

    function void check_result(bit [sedge_pkg::PixW-1:0] pix, bit last);
      edge_result_t want;
      if (expected_edges.size() == 0) begin
        $error("unexpected result: edge_pixel=%0d frame_end=%0d", pix, last);
        mismatch_count++;
        return;
      end
      want = expected_edges.pop_front();
      checked_count++;
      if (pix != want.edge_pixel) begin
        $error("edge_pixel mismatch: expected %0d, actual %0d", want.edge_pixel, pix);
        mismatch_count++;
      end
      if (last != want.frame_end) begin
        $error("frame_end mismatch: expected %0d, actual %0d", want.frame_end, last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [sedge_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [sedge_pkg::CfgW-1:0]    cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;

  edge_scoreboard sb = new();
  bit             steady;
  int unsigned    sink_holdoff;
  int unsigned    items_sent;
  int unsigned    stall_cycles;

  sobel_edge_threshold uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    if (rst_ni && s_axis_tvalid && !s_axis_tready) stall_cycles++;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_holdoff > 0) begin
        m_axis_tready <= 1'b0;
        sink_holdoff--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CycleLimit,
             sb.expected_edges.size());
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic bit [7:0] pick_pixel(texture_e tex, bit [7:0] base);
    case (tex)
      TexNoise:  return 8'($urandom_range(255));
      TexBinary: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:   return base + 8'($urandom_range(15));
    endcase
  endfunction

  function automatic bit [sedge_pkg::CfgW-1:0] random_threshold();
    case ($urandom_range(9))
      0:       return 11'd0;
      1:       return 11'd2047;
      2, 3:    return 11'($urandom_range(1, 60));
      default: return 11'($urandom_range(60, 1200));
    endcase
  endfunction

  task automatic send_item(bit [7:0] pix, bit flush);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= flush;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(pix, flush);
    items_sent++;
  endtask

  // drop valid, wait out every pending result and the pipeline tail
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_edges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(bit [sedge_pkg::CfgIdxW-1:0] idx, bit [sedge_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // pixels of one frame then the drain requests; stop early to abandon the frame
  task automatic send_frame(texture_e tex, int unsigned noise_pct,
                            int unsigned stop_after = 32'hFFFF_FFFF);
    int unsigned w, h, n;
    bit [7:0]    base;
    w = sb.dim_of(sb.width_reg, sedge_pkg::MaxWidthDef);
    h = sb.dim_of(sb.height_reg, sedge_pkg::MaxHeightDef);
    n = w * h + w + 1;
    if (stop_after < n) n = stop_after;
    base = 8'($urandom_range(255));
    for (int unsigned k = 0; k < n; k++) begin
      if (k < w * h) begin
        if ($urandom_range(99) < noise_pct) send_item(8'($urandom_range(255)), 1'b1);
        send_item(pick_pixel(tex, base), 1'b0);
      end else if ($urandom_range(99) < noise_pct) begin
        send_item(pick_pixel(tex, base), 1'b0);
      end else begin
        send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  task automatic random_geometry();
    settle();
    cfg_write(sedge_pkg::RegFrameWidth, ($urandom_range(9) == 0) ?
              11'($urandom_range(10, 40)) : 11'($urandom_range(1, 9)));
    cfg_write(sedge_pkg::RegFrameHeight, 11'($urandom_range(1, 6)));
    cfg_write(sedge_pkg::RegEdgeThreshold, random_threshold());
  endtask

  initial begin
    bit [7:0]    stripes[6];
    bit [7:0]    step_px[6];
    int unsigned frame_no, sel, w, h;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = sedge_pkg::RegFrameWidth;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    steady        = 1'b0;
    sink_holdoff  = 0;
    stripes = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    step_px = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero threshold: every pixel is an edge; early flush dropped, pixel in drain
    cfg_write(sedge_pkg::RegEdgeThreshold, 11'd0);
    cfg_write(sedge_pkg::RegFrameWidth, 11'd3);
    cfg_write(sedge_pkg::RegFrameHeight, 11'd2);
    send_item(8'hA5, 1'b1);
    foreach (stripes[i]) send_item(stripes[i], 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'd200, 1'b0);
    send_item(8'h5A, 1'b1);
    settle();

    // zero geometry acts as a single pixel; top threshold never fires
    cfg_write(sedge_pkg::RegEdgeThreshold, 11'd2047);
    cfg_write(sedge_pkg::RegFrameWidth, 11'd0);
    cfg_write(sedge_pkg::RegFrameHeight, 11'd0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    settle();

    cfg_write(sedge_pkg::RegEdgeThreshold, 11'd1);
    cfg_write(sedge_pkg::RegFrameWidth, 11'd2);
    cfg_write(sedge_pkg::RegFrameHeight, 11'd3);
    foreach (step_px[i]) send_item(step_px[i], 1'b0);
    repeat (3) send_item(8'h00, 1'b1);
    settle();

    // oversize geometry clamps to the maximum; both frames are abandoned part way
    cfg_write(sedge_pkg::RegEdgeThreshold, random_threshold());
    cfg_write(sedge_pkg::RegFrameWidth, 11'd2047);
    cfg_write(sedge_pkg::RegFrameHeight, 11'd2);
    send_frame(TexNoise, 0, 64);
    settle();
    cfg_write(sedge_pkg::RegFrameWidth, 11'd2);
    cfg_write(sedge_pkg::RegFrameHeight, 11'd2047);
    send_frame(TexRamp, 0, 80);
    random_geometry();

    frame_no = 0;
    while (items_sent < ItemTarget) begin
      steady = (frame_no >= 7 && frame_no < 12);
      sel    = $urandom_range(99);
      w      = sb.dim_of(sb.width_reg, sedge_pkg::MaxWidthDef);
      h      = sb.dim_of(sb.height_reg, sedge_pkg::MaxHeightDef);
      if (frame_no == 6) begin
        // hold the sink off long enough to back up the input
        settle();
        cfg_write(sedge_pkg::RegFrameWidth, 11'd8);
        cfg_write(sedge_pkg::RegFrameHeight, 11'd6);
        @(posedge clk_i);
        sink_holdoff = 150;
        send_frame(TexNoise, 0);
      end else if (sel < 15) begin
        send_frame(texture_e'($urandom_range(2)), 5, $urandom_range(1, w * h + w));
        settle();
        if ($urandom_range(1)) begin
          cfg_write(sedge_pkg::RegFrameHeight, 11'($urandom_range(1, 6)));
        end else begin
          cfg_write(sedge_pkg::RegFrameWidth, 11'($urandom_range(1, 9)));
        end
      end else begin
        if (sel < 55) begin
          random_geometry();
        end else if (sel < 75) begin
          settle();
          cfg_write(sedge_pkg::RegEdgeThreshold, random_threshold());
        end
        send_frame(texture_e'($urandom_range(2)), 4);
      end
      frame_no++;
    end

    steady = 1'b0;
    settle();
    $display("sent %0d requests, closed %0d frames, checked %0d results",
             items_sent, sb.frames_closed, sb.checked_count);
    $display("corner, oversize and abandoned frames run; input held off %0d cycles",
             stall_cycles);
    if (sb.mismatch_count == 0 && sb.expected_edges.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sedge_pkg.sv
rtl/sedge_front.sv
rtl/sedge_fifo.sv
rtl/sedge_back.sv
rtl/sobel_edge_threshold.sv
dv/tb_top.sv
